### src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; take in with `include before use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is asserted
`define ZD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("%m: property violated");

// property checked on every rising edge, reset included
`define ZD_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("%m: property violated");

`endif

### src/zdrtc_pkg.sv
// types, constants and helper functions of the zero drift rtc calendar
// no dependencies; used by the top level and the checker
package zdrtc_pkg;

	localparam int TICK_CLOCKS_DEF = 65536;
	localparam int YEAR_BITS_DEF   = 12;
	localparam int YEAR_FIELD_BITS = 12;
	localparam logic [31:0] CPS_RESET = 32'd10250000;
	localparam int YEAR_RESET      = 2000;
	localparam logic [5:0] SEC_PER_MIN = 6'd60;
	localparam logic [5:0] MIN_PER_HOUR = 6'd60;
	localparam logic [4:0] HOUR_PER_DAY = 5'd24;
	localparam logic [3:0] MONTH_LIMIT = 4'd13;

	typedef enum logic [1:0] {
		CMD_TICK     = 2'd0,
		CMD_INTERVAL = 2'd1,
		CMD_NEXT_MIN = 2'd2,
		CMD_SET_TIME = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] interval_seconds;
		logic [7:0]  minute_offset;
		logic [5:0]  set_second;
		logic [5:0]  set_minute;
		logic [4:0]  set_hour;
		logic [4:0]  set_day;
		logic [3:0]  set_month;
		logic [11:0] set_year;
	} item_t;

	typedef struct packed {
		logic        event_fired;
		logic [5:0]  next_minute;
		logic [5:0]  cur_second;
		logic [5:0]  cur_minute;
		logic [4:0]  cur_hour;
		logic [4:0]  cur_day;
		logic [3:0]  cur_month;
		logic [11:0] cur_year;
		logic [31:0] elapsed_count;
	} result_t;

	// days in a month; month 0 and 13..15 count as long months
	function automatic logic [5:0] month_length(input logic [3:0] month, input logic leap);
		logic [5:0] len;
		unique case (month)
			4'd2:                         len = leap ? 6'd29 : 6'd28;
			4'd4, 4'd6, 4'd9, 4'd11:      len = 6'd30;
			default:                      len = 6'd31;
		endcase
		return len;
	endfunction

	// remainder by 60 for values below 320, three compare and subtract steps
	function automatic logic [5:0] mod60(input logic [8:0] x);
		logic [8:0] r;
		r = x;
		if (r >= 9'd240) r = r - 9'd240;
		if (r >= 9'd120) r = r - 9'd120;
		if (r >= 9'd60)  r = r - 9'd60;
		return r[5:0];
	endfunction

endpackage

### src/zero_drift_rtc_calendar_top.sv
// zero drift real time clock with calendar, top level
// depends on zdrtc_pkg
// A command beat is taken into an input register, executed against the clock
// and calendar state once the result register is free, and its result beat
// lands in an output register; while a held result register blocks it, the
// command waits in the input register. One item is accepted every cycle for
// as long as results are taken. The rate is set by the single update stage
// between the input register and the result register, which reads and writes
// the time state in the same cycle. A tick
// models one timer overflow of TICK_CLOCKS clocks; each tick that drains the
// clock accumulator below TICK_CLOCKS reloads it with clocks_per_second and
// counts one second, so fractional seconds carry over and the time does not
// drift. clocks_per_second is written on the cfg port (cfg_ready is always
// high) and must only change while no command is in flight. item_stall rises
// only when the input register is full and the result register is held.
module zero_drift_rtc_calendar_top #(
	parameter int TICK_CLOCKS = zdrtc_pkg::TICK_CLOCKS_DEF,
	parameter int YEAR_BITS   = zdrtc_pkg::YEAR_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               item_valid,
	output logic               item_stall,
	input  zdrtc_pkg::item_t   item,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output zdrtc_pkg::result_t result,
	// clocks_per_second write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data
);

	localparam logic [32:0] TICK_W  = 33'(TICK_CLOCKS);
	localparam logic [32:0] TICK2_W = 33'(2 * TICK_CLOCKS);
	// wide enough for both the stored year and the year fields
	localparam int YEAR_EXT = (YEAR_BITS > zdrtc_pkg::YEAR_FIELD_BITS) ?
		YEAR_BITS : zdrtc_pkg::YEAR_FIELD_BITS;

	// pipeline registers
	logic               valid_s1;
	zdrtc_pkg::item_t   item_s1;
	logic               valid_s2;
	zdrtc_pkg::result_t result_s2;

	// clock and calendar state
	logic [32:0]          cps_adj_q;   // clocks_per_second minus one tick span
	logic [32:0]          acc_q;
	logic [5:0]           sec_q;
	logic [5:0]           min_q;
	logic [4:0]           hour_q;
	logic [4:0]           day_q;
	logic [3:0]           month_q;
	logic [YEAR_BITS-1:0] year_q;
	logic [31:0]          elapsed_q;

	// next state
	logic [32:0]          n_acc;
	logic [5:0]           n_sec;
	logic [5:0]           n_min;
	logic [4:0]           n_hour;
	logic [4:0]           n_day;
	logic [3:0]           n_month;
	logic [YEAR_BITS-1:0] n_year;
	logic [31:0]          n_elapsed;
	logic                 fired;
	logic [5:0]           next_min;

	logic s2_free;
	logic advance;
	logic load_s1;

	// handshake: input register refills while its item moves on
	assign s2_free    = !valid_s2 || !result_stall;
	assign advance    = valid_s1 && s2_free;
	assign item_stall = valid_s1 && !s2_free;
	assign load_s1    = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// command execution against the current state
	always_comb begin
		logic                 sec_due;
		logic [5:0]           sec1;
		logic [5:0]           min1;
		logic [4:0]           hour1;
		logic [5:0]           day1;
		logic [3:0]           month1;
		logic [YEAR_EXT-1:0]  set_year_ext;

		n_acc     = acc_q;
		n_sec     = sec_q;
		n_min     = min_q;
		n_hour    = hour_q;
		n_day     = day_q;
		n_month   = month_q;
		n_year    = year_q;
		n_elapsed = elapsed_q;
		fired     = 1'b0;
		next_min  = 6'd0;
		set_year_ext = YEAR_EXT'(item_s1.set_year);

		// after subtracting a tick the remainder is below one span exactly when
		// the accumulator sits in [span, 2*span)
		sec_due = (acc_q >= TICK_W) && (acc_q < TICK2_W);
		sec1    = sec_due ? (sec_q + 6'd1) : sec_q;
		min1    = min_q + 6'd1;
		hour1   = hour_q + 5'd1;
		day1    = {1'b0, day_q} + 6'd1;
		month1  = month_q;

		unique case (item_s1.command)
			zdrtc_pkg::CMD_TICK: begin
				n_acc = sec_due ? (acc_q + cps_adj_q) : (acc_q - TICK_W);
				if (sec_due) begin
					n_elapsed = elapsed_q + 32'd1;
				end
				// rollover runs on every tick, also for out of range values
				if (sec1 >= zdrtc_pkg::SEC_PER_MIN) begin
					n_sec = 6'd0;
					if (min1 >= zdrtc_pkg::MIN_PER_HOUR) begin
						n_min = 6'd0;
						if (hour1 >= zdrtc_pkg::HOUR_PER_DAY) begin
							n_hour = 5'd0;
							if (day1 > zdrtc_pkg::month_length(month_q,
									year_q[1:0] == 2'd0)) begin
								day1   = 6'd1;
								month1 = month_q + 4'd1;
							end
							n_day = day1[4:0];
							if (month1 >= zdrtc_pkg::MONTH_LIMIT) begin
								n_month = 4'd1;
								n_year  = year_q + YEAR_BITS'(1);
							end else begin
								n_month = month1;
							end
						end else begin
							n_hour = hour1;
						end
					end else begin
						n_min = min1;
					end
				end else begin
					n_sec = sec1;
				end
			end
			zdrtc_pkg::CMD_INTERVAL: begin
				if (item_s1.interval_seconds < elapsed_q) begin
					n_elapsed = 32'd0;
					fired     = 1'b1;
				end
			end
			zdrtc_pkg::CMD_NEXT_MIN: begin
				next_min = zdrtc_pkg::mod60({3'd0, min_q} + {1'b0, item_s1.minute_offset});
			end
			zdrtc_pkg::CMD_SET_TIME: begin
				n_sec   = item_s1.set_second;
				n_min   = item_s1.set_minute;
				n_hour  = item_s1.set_hour;
				n_day   = item_s1.set_day;
				n_month = item_s1.set_month;
				n_year  = set_year_ext[YEAR_BITS-1:0];
			end
		endcase
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			cps_adj_q <= 33'(zdrtc_pkg::CPS_RESET) - TICK_W;
			acc_q     <= 33'(zdrtc_pkg::CPS_RESET);
			sec_q     <= 6'd0;
			min_q     <= 6'd0;
			hour_q    <= 5'd0;
			day_q     <= 5'd1;
			month_q   <= 4'd1;
			year_q    <= YEAR_BITS'(zdrtc_pkg::YEAR_RESET);
			elapsed_q <= 32'd0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (s2_free) begin
				valid_s2 <= 1'b0;
			end
			// reload value is pre-reduced by one tick span at write time
			if (cfg_valid && cfg_ready) begin
				cps_adj_q <= {1'b0, cfg_data} - TICK_W;
			end
			if (advance) begin
				acc_q     <= n_acc;
				sec_q     <= n_sec;
				min_q     <= n_min;
				hour_q    <= n_hour;
				day_q     <= n_day;
				month_q   <= n_month;
				year_q    <= n_year;
				elapsed_q <= n_elapsed;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		logic [YEAR_EXT-1:0] year_ext;
		year_ext = YEAR_EXT'(n_year);
		if (load_s1) begin
			item_s1 <= item;
		end
		if (advance) begin
			result_s2.event_fired   <= fired;
			result_s2.next_minute   <= next_min;
			result_s2.cur_second    <= n_sec;
			result_s2.cur_minute    <= n_min;
			result_s2.cur_hour      <= n_hour;
			result_s2.cur_day       <= n_day;
			result_s2.cur_month     <= n_month;
			result_s2.cur_year      <= year_ext[zdrtc_pkg::YEAR_FIELD_BITS-1:0];
			result_s2.elapsed_count <= n_elapsed;
		end
	end

endmodule

### src/zdrtc_checker.sv
// port level checks for the zero drift rtc calendar, bound to the top level
// depends on zdrtc_pkg and assert_macros.svh
`include "assert_macros.svh"

module zdrtc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input logic               result_valid,
	input logic               result_stall,
	input zdrtc_pkg::result_t result
);

	logic item_beat;
	assign item_beat = item_valid && !item_stall;

	// no result beat on the edge after one that saw reset
	`ZD_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !result_valid)

	// a held result beat keeps its payload
	`ZD_ASSERT(a_result_hold, clk, arst_n,
		result_valid && result_stall |=> result_valid && $stable(result))

	// a fired interval event always restarts the elapsed count
	`ZD_ASSERT(a_fire_clears, clk, arst_n,
		result_valid && result.event_fired |-> result.elapsed_count == 32'd0)

	// a fresh result beat comes from an earlier command beat
	`ZD_ASSERT(a_result_origin, clk, arst_n,
		$rose(result_valid) |-> $past(item_beat, 2))

endmodule

bind zero_drift_rtc_calendar_top zdrtc_checker u_zdrtc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
